// ===== hdl/rtcm3_frame_checker_unit_assert.svh =====
// ----------------------------------------------------------------------------
// RTCM3 frame checker assertion macros
// Checks are active in simulation and compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef RTCM3_FRAME_CHECKER_UNIT_ASSERT_SVH
`define RTCM3_FRAME_CHECKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: cons must hold whenever ante holds.
`define RFC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtcm3 frame checker: implication check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define RFC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtcm3 frame checker: next-cycle check failed");

`else

`define RFC_ASSERT_IMP(label, clk, rst, ante, cons)
`define RFC_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/rtcm3fc_pkg.sv =====
// ----------------------------------------------------------------------------
// RTCM3 frame checker package
// Constants, result word layout and the byte-wide CRC-24Q update.
// ----------------------------------------------------------------------------
package rtcm3fc_pkg;

  // Framing constants.
  localparam int          MAX_FRAME_BYTES_DEF = 1029;
  localparam int          MIN_FRAME_BYTES     = 6;
  localparam int          LEN_SUM_W           = 11;
  localparam logic [7:0]  PREAMBLE            = 8'hD3;
  localparam logic [7:0]  RESERVED_MASK       = 8'hFC;
  localparam logic [24:0] CRC_POLY            = 25'h1864CFB;
  localparam int          OUT_TDATA_W         = 40;

  // Result codes, first failing check wins.
  typedef enum logic [2:0] {
    ERR_OK       = 3'd0,
    ERR_SIZE     = 3'd1,
    ERR_PREAMBLE = 3'd2,
    ERR_RESERVED = 3'd3,
    ERR_LENGTH   = 3'd4,
    ERR_CRC      = 3'd5
  } err_code_t;

  // Result word, frame_ok in bit 0, padded to whole bytes at the top.
  typedef struct packed {
    logic [1:0]  pad;
    logic [23:0] computed_crc;
    logic [9:0]  payload_length;
    err_code_t   error_code;
    logic        frame_ok;
  } out_word_t;

  // Folds one byte into a CRC-24Q value, eight shift steps unrolled.
  function automatic logic [23:0] crc24q_byte(input logic [23:0] crc_in,
                                              input logic [7:0]  b);
    logic [24:0] c;
    c = {1'b0, crc_in ^ {b, 16'h0000}};
    for (int k = 0; k < 8; k++) begin
      c = {c[23:0], 1'b0};
      if (c[24]) begin
        c = c ^ CRC_POLY;
      end
    end
    return c[23:0];
  endfunction

endpackage

// ===== hdl/rtcm3_frame_checker_unit.sv =====
// ----------------------------------------------------------------------------
// RTCM3 frame checker
// Checks one RTCM3 frame per run of bytes: frame size, preamble, reserved
// bits, length field and the CRC-24Q, and reports one result word per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_axis: one frame byte per word, s_axis_tlast on the final
//   byte of the frame. Output channel m_axis: one result word per frame,
//   produced for the word that carried s_axis_tlast.
//   The byte-wide CRC update and the frame state registers accept one word
//   every clock while the result register is free.
//   A result appears on m_axis in the cycle after the last byte is accepted.
//   The result register doubles as the stall buffer: while a result waits
//   for m_axis_tready, s_axis_tready is low; when the result is taken in the
//   same cycle a new byte can be accepted, so throughput stays one byte per
//   cycle with an ever-ready receiver.
//   Frames longer than MAX_FRAME_BYTES keep running through the CRC and end
//   with a size error. The frame state clears after each final byte.
//   Reset (rst, synchronous) clears the frame state and empties the result
//   register; no result is pending afterwards.
// ----------------------------------------------------------------------------
module rtcm3_frame_checker_unit #(
  parameter int MAX_FRAME_BYTES = rtcm3fc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [7:0] data_byte
  input  logic [7:0]                          s_axis_tdata,
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] frame_ok, [3:1] error_code, [13:4] payload_length,
  // [37:14] computed_crc, [39:38] zero
  output logic [rtcm3fc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  import rtcm3fc_pkg::*;

  `include "rtcm3_frame_checker_unit_assert.svh"

  localparam int             CNT_W   = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_FRAME_BYTES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);
  localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME_BYTES);

  // Frame state.
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [23:0]      running_crc, running_crc_next;
  logic [7:0]       tail_bytes [3];
  logic [7:0]       tail_bytes_next [3];
  logic             preamble_good, preamble_good_next;
  logic             reserved_good, reserved_good_next;
  logic [9:0]       length_field, length_field_next;

  // Result register.
  logic      out_valid;
  out_word_t out_data;
  out_word_t result;

  logic s_fire;
  logic [LEN_SUM_W-1:0] len_sum;
  err_code_t err;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // Header captures, delay line, CRC and byte count for the current word.
  always_comb begin
    preamble_good_next = preamble_good;
    reserved_good_next = reserved_good;
    length_field_next  = length_field;
    if (byte_count == CNT_W'(0)) begin
      preamble_good_next = (s_axis_tdata == PREAMBLE);
    end else if (byte_count == CNT_W'(1)) begin
      reserved_good_next = ((s_axis_tdata & RESERVED_MASK) == 8'h00);
      length_field_next  = {s_axis_tdata[1:0], length_field[7:0]};
    end else if (byte_count == CNT_W'(2)) begin
      length_field_next  = {length_field[9:8], s_axis_tdata};
    end

    running_crc_next = running_crc;
    if (byte_count >= CNT_W'(3)) begin
      running_crc_next = crc24q_byte(running_crc, tail_bytes[0]);
    end
    tail_bytes_next[0] = tail_bytes[1];
    tail_bytes_next[1] = tail_bytes[2];
    tail_bytes_next[2] = s_axis_tdata;

    byte_count_next = byte_count;
    if (byte_count < CNT_SAT) begin
      byte_count_next = byte_count + CNT_W'(1);
    end
  end

  // Frame checks in priority order, evaluated on the updated state.
  assign len_sum = {1'b0, length_field_next} + LEN_SUM_W'(MIN_FRAME_BYTES);

  always_comb begin
    if (byte_count_next < CNT_MIN || byte_count_next > CNT_MAX) begin
      err = ERR_SIZE;
    end else if (!preamble_good_next) begin
      err = ERR_PREAMBLE;
    end else if (!reserved_good_next) begin
      err = ERR_RESERVED;
    end else if (len_sum != LEN_SUM_W'(byte_count_next)) begin
      err = ERR_LENGTH;
    end else if (running_crc_next !=
                 {tail_bytes_next[0], tail_bytes_next[1], tail_bytes_next[2]}) begin
      err = ERR_CRC;
    end else begin
      err = ERR_OK;
    end
    result.pad            = 2'b00;
    result.computed_crc   = running_crc_next;
    result.payload_length = length_field_next;
    result.error_code     = err;
    result.frame_ok       = (err == ERR_OK);
  end

  // Frame state registers; the final byte returns them to the idle frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      running_crc   <= '0;
      tail_bytes[0] <= '0;
      tail_bytes[1] <= '0;
      tail_bytes[2] <= '0;
      preamble_good <= 1'b0;
      reserved_good <= 1'b0;
      length_field  <= '0;
    end else if (s_fire) begin
      if (s_axis_tlast) begin
        byte_count    <= '0;
        running_crc   <= '0;
        tail_bytes[0] <= '0;
        tail_bytes[1] <= '0;
        tail_bytes[2] <= '0;
        preamble_good <= 1'b0;
        reserved_good <= 1'b0;
        length_field  <= '0;
      end else begin
        byte_count    <= byte_count_next;
        running_crc   <= running_crc_next;
        tail_bytes[0] <= tail_bytes_next[0];
        tail_bytes[1] <= tail_bytes_next[1];
        tail_bytes[2] <= tail_bytes_next[2];
        preamble_good <= preamble_good_next;
        reserved_good <= reserved_good_next;
        length_field  <= length_field_next;
      end
    end
  end

  // Result register, loaded on the final byte and held until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_fire && s_axis_tlast) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && s_axis_tlast) begin
      out_data <= result;
    end
  end

  // A new result only follows a final byte.
  `RFC_ASSERT_IMP(a_result_from_last, clk, rst, $rose(out_valid),
                  $past(s_fire && s_axis_tlast))
  // The frame state is back at its start after a final byte.
  `RFC_ASSERT_NXT(a_state_cleared, clk, rst, s_fire && s_axis_tlast,
                  byte_count == '0 && running_crc == '0 && !preamble_good)
  // The ok flag agrees with the error code.
  `RFC_ASSERT_IMP(a_ok_matches_code, clk, rst, out_valid,
                  out_data.frame_ok == (out_data.error_code == ERR_OK))

endmodule
